// ===== rtl/core/tmrd_pkg.sv =====
`default_nettype none

package tmrd_pkg;

	localparam int HeaderBytes = 12;
	localparam logic [31:0] USEC_PER_SEC = 32'd1000000;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_START   = 2'd1;
	localparam logic [1:0] KIND_DELAY   = 2'd2;

	// Work item handed from the front part to the back part.
	typedef struct packed {
		logic        is_header;
		logic [7:0]  data;
		logic        eor;
		logic [31:0] sec;
		logic [31:0] usec;
	} tmrd_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         data_byte;
		logic signed [32:0] time_sec;
		logic signed [32:0] time_usec;
		logic               end_of_record;
		logic               usec_out_of_range;
	} tmrd_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/tmrd_fifo.sv =====
`default_nettype none

module tmrd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tmrd_front.sv =====
`default_nettype none

module tmrd_front
	import tmrd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] stream_byte,
	output logic            full,
	input  wire logic       item_full,
	output logic            item_push,
	output tmrd_item_t      item
);

	localparam logic [3:0] LAST_HDR = 4'(HeaderBytes - 1);

	logic [3:0]  hdr_cnt_q;
	logic        in_payload_q;
	logic [31:0] sec_q;
	logic [31:0] usec_q;
	logic [31:0] len_q;
	logic [31:0] remain_q;

	logic        accept;
	logic [31:0] remain_next;
	logic        is_last;
	logic        hdr_done;
	logic [31:0] len_next;

	assign full        = item_full;
	assign accept      = push & ~item_full;
	assign remain_next = remain_q - 32'd1;
	assign is_last     = (remain_next == '0);
	assign hdr_done    = ~in_payload_q & (hdr_cnt_q == LAST_HDR);
	assign len_next    = {stream_byte, len_q[31:8]};

	// Every payload byte and every completed header makes one item for the back part.
	assign item_push      = accept & (in_payload_q | hdr_done);
	assign item.is_header = ~in_payload_q;
	assign item.data      = stream_byte;
	assign item.eor       = in_payload_q & is_last;
	assign item.sec       = sec_q;
	assign item.usec      = usec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q    <= '0;
			in_payload_q <= 1'b0;
			sec_q        <= '0;
			usec_q       <= '0;
			len_q        <= '0;
			remain_q     <= '0;
		end else if (accept) begin
			if (in_payload_q) begin
				remain_q <= remain_next;
				if (is_last) begin
					in_payload_q <= 1'b0;
					hdr_cnt_q    <= '0;
				end
			end else begin
				// Fields arrive least significant byte first.
				priority if (hdr_cnt_q < 4'd4) begin
					sec_q <= {stream_byte, sec_q[31:8]};
				end else if (hdr_cnt_q < 4'd8) begin
					usec_q <= {stream_byte, usec_q[31:8]};
				end else begin
					len_q <= len_next;
				end
				if (hdr_done) begin
					hdr_cnt_q <= '0;
					if (len_next != '0) begin
						in_payload_q <= 1'b1;
						remain_q     <= len_next;
					end
				end else begin
					hdr_cnt_q <= hdr_cnt_q + 4'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tmrd_back.sv =====
`default_nettype none

module tmrd_back
	import tmrd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire tmrd_item_t item,
	input  wire logic       item_empty,
	output logic            item_pop,
	input  wire logic       res_full,
	output logic            res_push,
	output tmrd_result_t    res
);

	logic [31:0] prev_sec_q;
	logic [31:0] prev_usec_q;
	logic        first_q;

	logic        take;
	logic        flag;
	logic [32:0] sec_ext;
	logic [32:0] usec_ext;
	logic [32:0] sec_diff;
	logic [32:0] sec_diff_m1;
	logic [32:0] usec_diff;
	logic [32:0] usec_wrap;
	logic        borrow;

	assign take     = ~item_empty & ~res_full;
	assign item_pop = take;
	assign res_push = take;

	assign sec_ext  = {1'b0, item.sec};
	assign usec_ext = {1'b0, item.usec};
	assign flag     = (item.usec >= USEC_PER_SEC);

	// Both borrow outcomes are formed side by side; the usec sign picks one.
	assign sec_diff    = sec_ext - {1'b0, prev_sec_q};
	assign sec_diff_m1 = sec_ext + ~{1'b0, prev_sec_q};
	assign usec_diff   = usec_ext - {1'b0, prev_usec_q};
	assign usec_wrap   = usec_ext - {1'b0, prev_usec_q} + {1'b0, USEC_PER_SEC};
	assign borrow      = usec_diff[32];

	always_comb begin
		res = '0;
		if (!item.is_header) begin
			res.kind          = KIND_PAYLOAD;
			res.data_byte     = item.data;
			res.end_of_record = item.eor;
		end else if (first_q) begin
			res.kind              = KIND_START;
			res.time_sec          = sec_ext;
			res.time_usec         = usec_ext;
			res.usec_out_of_range = flag;
		end else begin
			res.kind              = KIND_DELAY;
			res.time_sec          = borrow ? sec_diff_m1 : sec_diff;
			res.time_usec         = borrow ? usec_wrap : usec_diff;
			res.usec_out_of_range = flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sec_q  <= '0;
			prev_usec_q <= '0;
			first_q     <= 1'b1;
		end else if (take && item.is_header) begin
			prev_sec_q  <= item.sec;
			prev_usec_q <= item.usec;
			first_q     <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/timed_record_deframer.sv =====
`default_nettype none

// Channel  Direction  Handshake    Payload
// input    in         push / full  stream_byte
// result   out        pop / empty  kind, data_byte, time_sec, time_usec,
//                                  end_of_record, usec_out_of_range
//
// One byte is accepted per cycle while full is low; each item is registered in the item
// queue and its result in the result queue before the result is ready for transfer.
// The front parser's byte-by-byte assembly and the back timing unit's combinational
// 33-bit subtracts set the rate of one byte per cycle while neither queue is full.
// Reset is asynchronous and clears the parser, the previous timestamp and both queues.
// A stalled result side fills the result queue, then the item queue, then raises full.
module timed_record_deframer
	import tmrd_pkg::*;
#(
	parameter int ITEM_DEPTH   = 4,
	parameter int RESULT_DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [7:0]    stream_byte,
	output logic               full,
	output logic               empty,
	input  wire logic          pop,
	output logic [1:0]         kind,
	output logic [7:0]         data_byte,
	output logic signed [32:0] time_sec,
	output logic signed [32:0] time_usec,
	output logic               end_of_record,
	output logic               usec_out_of_range
);

	tmrd_item_t   front_item;
	tmrd_item_t   back_item;
	logic         item_push;
	logic         item_full;
	logic         item_pop;
	logic         item_empty;
	tmrd_result_t back_res;
	tmrd_result_t out_res;
	logic         res_push;
	logic         res_full;

	tmrd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.stream_byte(stream_byte),
		.full       (full),
		.item_full  (item_full),
		.item_push  (item_push),
		.item       (front_item)
	);

	tmrd_fifo #(
		.WIDTH($bits(tmrd_item_t)),
		.DEPTH(ITEM_DEPTH)
	) u_item_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (item_push),
		.wdata (front_item),
		.full  (item_full),
		.pop   (item_pop),
		.rdata (back_item),
		.empty (item_empty)
	);

	tmrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (back_item),
		.item_empty(item_empty),
		.item_pop  (item_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res)
	);

	tmrd_fifo #(
		.WIDTH($bits(tmrd_result_t)),
		.DEPTH(RESULT_DEPTH)
	) u_result_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (back_res),
		.full  (res_full),
		.pop   (pop),
		.rdata (out_res),
		.empty (empty)
	);

	assign kind              = out_res.kind;
	assign data_byte         = out_res.data_byte;
	assign time_sec          = out_res.time_sec;
	assign time_usec         = out_res.time_usec;
	assign end_of_record     = out_res.end_of_record;
	assign usec_out_of_range = out_res.usec_out_of_range;

endmodule

`default_nettype wire
